// File: src/tkpq_pkg.sv
// Package: shared types and constants of the two-key priority queue.
`timescale 1ns / 1ps
package tkpq_pkg;

    // Default queue depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // Field widths
    localparam int PRIO_W   = 3;
    localparam int AGE_W    = 8;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Opcodes of an input beat
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_SERVED   = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_FULL     = 2'd3
    } t_status;

    // One queue entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [AGE_W-1:0]  age;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture a new result beat
        logic ins;    // insert the new entry into the sorted array
        logic srv;    // pop the head entry
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_stat;

endpackage

// File: src/tkpq_if.sv
// Interfaces: request and result channels of the two-key priority queue.
`timescale 1ns / 1ps
interface tkpq_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [tkpq_pkg::PRIO_W-1:0] priority_req;
    logic [tkpq_pkg::AGE_W-1:0]  age;
    logic [tkpq_pkg::TAG_W-1:0]  tag;

    modport source (output valid, opcode, priority_req, age, tag, input ready);
    modport sink   (input valid, opcode, priority_req, age, tag, output ready);
endinterface

interface tkpq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tkpq_pkg::STATUS_W-1:0] status;
    logic [tkpq_pkg::PRIO_W-1:0]   out_priority;
    logic [tkpq_pkg::AGE_W-1:0]    out_age;
    logic [tkpq_pkg::TAG_W-1:0]    out_tag;
    logic [tkpq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, out_priority, out_age, out_tag, occupancy,
                    input ready);
    modport sink   (input valid, status, out_priority, out_age, out_tag, occupancy,
                    output ready);
endinterface

// File: src/tkpq_ctrl.sv
// Controller: beat handshake, result status and datapath commands.
`timescale 1ns / 1ps
module tkpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_opcode,
    input  logic              i_out_ready,
    input  tkpq_pkg::t_stat   i_stat,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output tkpq_pkg::t_status o_status,
    output tkpq_pkg::t_cmd    o_cmd
);
    import tkpq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    w_take;

    // A new beat may enter when no result waits or the waiting one leaves now
    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign w_take      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_HOLD);
    assign o_status    = r_status;

    // Commands and next state
    always_comb begin
        o_cmd.load = w_take;
        o_cmd.ins  = w_take && (i_opcode == OP_INSERT) && !i_stat.full;
        o_cmd.srv  = w_take && (i_opcode == OP_SERVE) && !i_stat.empty;
        n_status   = r_status;
        n_state    = r_state;
        if (w_take) begin
            n_state = S_HOLD;
            if (i_opcode == OP_INSERT) begin
                n_status = i_stat.full ? STATUS_FULL : STATUS_INSERTED;
            end else begin
                n_status = i_stat.empty ? STATUS_EMPTY : STATUS_SERVED;
            end
        end else if (i_out_ready) begin
            n_state = S_IDLE;
        end
    end

    // State and registered status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= STATUS_INSERTED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

// File: src/tkpq_dp.sv
// Datapath: sorted shift-register array of compare cells and result registers.
`timescale 1ns / 1ps
module tkpq_dp #(
    parameter int QUEUE_DEPTH = tkpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tkpq_pkg::t_cmd               i_cmd,
    input  tkpq_pkg::t_entry             i_new,
    output tkpq_pkg::t_stat              o_stat,
    output logic [tkpq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [tkpq_pkg::AGE_W-1:0]   o_out_age,
    output logic [tkpq_pkg::TAG_W-1:0]   o_out_tag,
    output logic [tkpq_pkg::OCC_W-1:0]   o_occupancy
);
    import tkpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_entry [QUEUE_DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [QUEUE_DEPTH-1:0] w_after;
    t_entry             r_out;

    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Each cell flags whether the new entry goes ahead of it (empty cells count)
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_after[i] = (CNT_W'(i) >= r_count)
                      || (r_entry[i].prio > i_new.prio)
                      || ((r_entry[i].prio == i_new.prio) && (r_entry[i].age < i_new.age));
        end
    end

    // Cells: insert shifts toward the tail, serve shifts toward the head
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.ins && w_after[g]) begin
                if (g == 0) begin
                    r_entry[g] <= i_new;
                end else if (!w_after[(g == 0) ? 0 : g - 1]) begin
                    r_entry[g] <= i_new;
                end else begin
                    r_entry[g] <= r_entry[(g == 0) ? 0 : g - 1];
                end
            end else if (i_cmd.srv && (g < QUEUE_DEPTH - 1)) begin
                r_entry[g] <= r_entry[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.srv) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Result payload: head on a serve, zero otherwise
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= i_cmd.srv ? r_entry[0] : '0;
        end
    end

    assign o_out_priority = r_out.prio;
    assign o_out_age      = r_out.age;
    assign o_out_tag      = r_out.tag;
    assign o_occupancy    = OCC_W'(r_count);

endmodule

// File: src/two_key_priority_queue.sv
// Top level: bounded sorted priority queue with controller and datapath.
// Takes one beat per clock while no result stalls: insert or serve. Entries sit
// in a sorted register array of QUEUE_DEPTH compare cells, head first, ordered
// by ascending priority, then descending age, then arrival order. An insert or a
// serve is done at acceptance by one parallel compare-and-shift across the cell
// array; the result beat appears in the output register the next cycle and a
// new request is taken in the same cycle the waiting result leaves.
// A stalled result holds off further requests. An insert into a full queue is
// dropped with status 3; a serve of an empty queue returns status 2 and zeros.
// Occupancy shows the low 5 bits of the entry count. No clearing pass is needed.
`timescale 1ns / 1ps
module two_key_priority_queue #(
    parameter int QUEUE_DEPTH = tkpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tkpq_req_if.sink   i_req,
    tkpq_rsp_if.source o_rsp
);
    import tkpq_pkg::*;

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_status w_status;
    t_entry  w_new;

    assign w_new.prio = i_req.priority_req;
    assign w_new.age  = i_req.age;
    assign w_new.tag  = i_req.tag;

    // Controller
    tkpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_opcode    (i_req.opcode),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath
    tkpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_new          (w_new),
        .o_stat         (w_stat),
        .o_out_priority (o_rsp.out_priority),
        .o_out_age      (o_rsp.out_age),
        .o_out_tag      (o_rsp.out_tag),
        .o_occupancy    (o_rsp.occupancy)
    );

    assign o_rsp.status = w_status;

endmodule

// File: src/tkpq_chk.sv
// Checker: port-level assertions for the two-key priority queue, with bind.
`timescale 1ns / 1ps
module tkpq_chk #(
    parameter int QUEUE_DEPTH = tkpq_pkg::QUEUE_DEPTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tkpq_pkg::STATUS_W-1:0] i_status,
    input logic [tkpq_pkg::PRIO_W-1:0]   i_out_priority,
    input logic [tkpq_pkg::AGE_W-1:0]    i_out_age,
    input logic [tkpq_pkg::TAG_W-1:0]    i_out_tag,
    input logic [tkpq_pkg::OCC_W-1:0]    i_occupancy
);
    import tkpq_pkg::*;

    // An accepted request yields a result beat on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("no result beat after accepted request");

    // Non-serve results carry zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != STATUS_SERVED))
        |-> ((i_out_priority == '0) && (i_out_age == '0) && (i_out_tag == '0)))
        else $error("nonzero data on a non-serve result");

    // Empty report only with nothing held
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == STATUS_EMPTY)) |-> (i_occupancy == '0))
        else $error("empty status with entries held");

    // Full report only at capacity
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == STATUS_FULL)) |-> (i_occupancy == OCC_W'(QUEUE_DEPTH)))
        else $error("full status below capacity");

    // Stalled result beat holds its status, tag and occupancy
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_status) && $stable(i_out_tag) && $stable(i_occupancy)))
        else $error("stalled result beat changed");

endmodule

bind two_key_priority_queue tkpq_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_out_priority (o_rsp.out_priority),
    .i_out_age      (o_rsp.out_age),
    .i_out_tag      (o_rsp.out_tag),
    .i_occupancy    (o_rsp.occupancy)
);
